### hw/rtl/paf_pkg.sv
// ----------------------------------------------------------------------------
// paf_pkg: shared types and codes of the partition allocator
// Operation, status, policy and register codes, the sequencer state and entry types.
// ----------------------------------------------------------------------------
package paf_pkg;

	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_APPEND = 3'd1,
		OP_ALLOC  = 3'd2,
		OP_FREE   = 3'd3,
		OP_LOOKUP = 3'd4
	} op_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOFIT   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_NOOWNER = 2'd3;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;

	localparam logic [1:0] REG_DYNAMIC = 2'd0;
	localparam logic [1:0] REG_POLICY  = 2'd1;
	localparam logic [1:0] REG_MEMSIZE = 2'd2;

	localparam logic [31:0] MEMSIZE_RESET = 32'd4096;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,     // fit or owner search; append reads the last entry
		S_DECIDE,
		S_SHUP,     // move entries up one place, top first
		S_SPLIT,
		S_FREE_NX,  // read next neighbor
		S_FREE_PV,  // read previous neighbor
		S_SHDN,     // move entries down one or two places
		S_OUT
	} state_t;

	typedef struct packed {
		logic [95:0] data; // {base, size, owner}
		logic        used;
	} entry_t;

endpackage

### hw/rtl/paf_table.sv
// ----------------------------------------------------------------------------
// paf_table: partition table storage
// One read port with registered data and one write port.
// ----------------------------------------------------------------------------
module paf_table #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  paf_pkg::entry_t     wdata,
	input  logic [AW-1:0]       raddr,
	output paf_pkg::entry_t     rdata
);
	import paf_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/partition_allocator_fit_top.sv
// ----------------------------------------------------------------------------
// partition_allocator_fit_top: first/best/worst fit partition allocator
// Ordered partition table with init, append, allocate, free and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries mode, req_size, req_pid. One
//   transfer is taken only while the block is idle; in_stall is high while an
//   operation runs or its result waits. Each operation produces exactly one
//   result on the output channel (out_valid/out_stall); it holds while
//   out_stall is high, and the next item is taken the cycle after it is gone.
//   The config channel (cfg_valid/cfg_ready) writes dynamic_scheme,
//   fit_policy, memory_size by index; write it only while idle.
// Table access: allocate, free and lookup scan the entries in order through
//   the single table read port, with a decide step after the scan. A split
//   shifts the entries above the found one up for the remainder; a dynamic
//   free reads both neighbors, merges free ones and shifts entries down.
//   Init, unknown modes and appends to an empty or full table read nothing;
//   other appends read the last entry.
// Reset: the table is emptied (count 0), control registers take reset values.
//   Table contents are not cleared; only entries below the count are read.
// ----------------------------------------------------------------------------
module partition_allocator_fit_top #(
	parameter int MAX_PARTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [31:0] req_size,
	input  logic [31:0] req_pid,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [4:0]  part_index,
	output logic [31:0] part_base_out,
	output logic [31:0] part_limit_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import paf_pkg::*;

	localparam int AW = $clog2(MAX_PARTS);
	localparam int CW = $clog2(MAX_PARTS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_PARTS);

	state_t state_q, state_d;

	logic        dyn_q;
	logic [1:0]  pol_q;
	logic [31:0] msize_q;

	logic [2:0]  op_q;
	logic [31:0] rsize_q, rpid_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;   // scan / shift position
	logic          phase_q; // 0 issue read, 1 data back
	logic          hit_q;
	logic          gap2_q;  // shift down by two places
	logic [AW-1:0] sel_q;
	logic [31:0]   sbase_q, ssize_q;
	logic [31:0]   nsize_q; // merged size being built
	logic [1:0]    rstat_q;
	logic [AW-1:0] ridx_q;
	logic [31:0]   rbase_q, rlim_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	entry_t        wdata, rdata;

	logic [31:0] rd_base, rd_size, rd_owner;
	assign rd_base  = rdata.data[95:64];
	assign rd_size  = rdata.data[63:32];
	assign rd_owner = rdata.data[31:0];

	paf_table #(.DEPTH(MAX_PARTS), .AW(AW)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic in_xfer, out_xfer;
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = (state_q == S_OUT);
	assign status = rstat_q;
	assign part_index = 5'(ridx_q);
	assign part_base_out = rbase_q;
	assign part_limit_out = rlim_q;

	// scan candidate tests (rdata is entry ptr_q when phase_q)
	logic fit_ok, better, own_ok;
	assign fit_ok = !rdata.used && (rd_size >= rsize_q);
	always_comb begin
		case (pol_q)
			FIT_BEST:  better = rd_size < ssize_q;
			FIT_WORST: better = rd_size > ssize_q;
			default:   better = 1'b0;
		endcase
	end
	assign own_ok = rdata.used && (rd_owner == rpid_q);
	logic scan_stop;
	assign scan_stop = (op_q == OP_ALLOC) ?
		(fit_ok && !hit_q && pol_q != FIT_BEST && pol_q != FIT_WORST) : own_ok;

	logic [CW-1:0] sel_ext;
	assign sel_ext = CW'(sel_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					if (mode == OP_ALLOC || mode == OP_FREE || mode == OP_LOOKUP) begin
						state_d = S_SCAN;
					end else if (mode == OP_APPEND && cnt_q != '0 && cnt_q < FULL) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_OUT;
					end
				end
			end
			S_SCAN: begin
				if (op_q == OP_APPEND) begin
					if (phase_q) state_d = S_OUT;
				end else if (ptr_q >= cnt_q) begin
					state_d = S_DECIDE;
				end else if (phase_q && scan_stop) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!hit_q) begin
					state_d = S_OUT;
				end else if (op_q == OP_ALLOC) begin
					if (dyn_q && ssize_q != rsize_q && cnt_q < FULL) state_d = S_SHUP;
					else state_d = S_OUT;
				end else if (op_q == OP_FREE && dyn_q) begin
					state_d = S_FREE_NX;
				end else begin
					state_d = S_OUT;
				end
			end
			S_SHUP:    if (ptr_q <= sel_ext + 1'b1) state_d = S_SPLIT;
			S_SPLIT:   state_d = S_OUT;
			S_FREE_NX: if (phase_q) state_d = S_FREE_PV;
			S_FREE_PV: if (phase_q || sel_q == '0) state_d = S_SHDN;
			S_SHDN: begin
				if (ptr_q >= cnt_q || (phase_q && ptr_q + 1'b1 >= cnt_q)) state_d = S_OUT;
			end
			S_OUT:     if (out_xfer) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// merge bookkeeping: after FREE_NX/PV, ptr_q is the first slot to be
	// refilled from above
	logic nx_free, pv_free;
	assign nx_free = (CW'(sel_q) + 1'b1 < cnt_q) && !rdata.used;
	assign pv_free = !rdata.used;

	// table access
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = ptr_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				raddr = AW'(cnt_q - 1'b1);
				if (in_xfer && mode == OP_INIT && dyn_q) begin
					we = 1'b1;
					wdata.data = {32'd0, msize_q, 32'd0};
				end
				if (in_xfer && mode == OP_APPEND && cnt_q == '0) begin
					we = 1'b1;
					wdata.data = {32'd0, req_size, 32'd0};
				end
			end
			S_SCAN: begin
				raddr = (op_q == OP_APPEND) ? AW'(cnt_q - 1'b1) : ptr_q[AW-1:0];
				if (op_q == OP_APPEND && phase_q && cnt_q < FULL) begin
					we = 1'b1;
					waddr = AW'(cnt_q);
					wdata.data = {rd_base + rd_size, rsize_q, 32'd0};
				end
			end
			S_DECIDE: begin
				if (hit_q && op_q == OP_ALLOC &&
				    !(dyn_q && ssize_q != rsize_q)) begin
					we = 1'b1;
					waddr = sel_q;
					wdata.data = {sbase_q, ssize_q, rpid_q};
					wdata.used = 1'b1;
				end
				if (hit_q && op_q == OP_FREE) begin
					we = 1'b1;
					waddr = sel_q;
					wdata.data = {sbase_q, ssize_q, 32'd0};
				end
				raddr = AW'(cnt_q - 1'b1);
			end
			S_SHUP: begin
				if (ptr_q == sel_ext + 1'b1) begin
					// split remainder lands just above the allocated entry
					we = 1'b1;
					waddr = sel_q + 1'b1;
					wdata.data = {sbase_q + rsize_q, ssize_q - rsize_q, 32'd0};
				end else begin
					// ptr_q = destination; data of ptr-1 arrives when phase_q
					raddr = phase_q ? AW'(ptr_q - 2'd2) : AW'(ptr_q - 1'b1);
					we = phase_q;
					waddr = ptr_q[AW-1:0];
					wdata = rdata;
				end
			end
			S_SPLIT: begin
				we = 1'b1;
				waddr = sel_q;
				wdata.data = {sbase_q, rsize_q, rpid_q};
				wdata.used = 1'b1;
			end
			S_FREE_NX: raddr = sel_q + 1'b1;
			S_FREE_PV: begin
				raddr = sel_q - 1'b1;
				if (phase_q && sel_q != '0 && pv_free) begin
					// previous neighbor absorbs the freed entry
					we = 1'b1;
					waddr = sel_q - 1'b1;
					wdata.data = {rd_base, rd_size + nsize_q, 32'd0};
				end else if (phase_q || sel_q == '0) begin
					we = 1'b1;
					waddr = sel_q;
					wdata.data = {sbase_q, nsize_q, 32'd0};
				end
			end
			S_SHDN: begin
				raddr = AW'(ptr_q + (gap2_q ? CW'(2) : CW'(1)) + (phase_q ? CW'(1) : CW'(0)));
				we = phase_q;
				waddr = ptr_q[AW-1:0];
				wdata = rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dyn_q   <= 1'b0;
			pol_q   <= FIT_FIRST;
			msize_q <= MEMSIZE_RESET;
			cnt_q   <= '0;
			ptr_q   <= '0;
			phase_q <= 1'b0;
			hit_q   <= 1'b0;
			gap2_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DYNAMIC: dyn_q   <= cfg_data[0];
					REG_POLICY:  pol_q   <= cfg_data[1:0];
					REG_MEMSIZE: msize_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					ptr_q <= '0;
					phase_q <= 1'b0;
					hit_q <= 1'b0;
					if (in_xfer && mode == OP_INIT) cnt_q <= dyn_q ? CW'(1) : '0;
					if (in_xfer && mode == OP_APPEND && cnt_q == '0) cnt_q <= CW'(1);
				end
				S_SCAN: begin
					if (op_q == OP_APPEND) begin
						phase_q <= 1'b1;
						if (phase_q) cnt_q <= cnt_q + 1'b1;
					end else if (ptr_q < cnt_q) begin
						phase_q <= !phase_q;
						if (phase_q) begin
							ptr_q <= ptr_q + 1'b1;
							if ((op_q == OP_ALLOC && fit_ok && (!hit_q || better)) ||
							    (op_q != OP_ALLOC && own_ok)) begin
								hit_q <= 1'b1;
							end
						end
					end
				end
				S_DECIDE: begin
					phase_q <= 1'b0;
					if (hit_q && op_q == OP_ALLOC && dyn_q && ssize_q != rsize_q &&
					    cnt_q < FULL) begin
						ptr_q <= cnt_q;  // first destination; read cnt-1 issued now
					end
				end
				S_SHUP: begin
					phase_q <= 1'b1;
					if (phase_q && ptr_q != sel_ext + 1'b1) ptr_q <= ptr_q - 1'b1;
				end
				S_SPLIT: cnt_q <= cnt_q + 1'b1;
				S_FREE_NX: begin
					phase_q <= !phase_q;
					ptr_q <= (phase_q && nx_free) ? sel_ext + CW'(1) : '0;
				end
				S_FREE_PV: begin
					phase_q <= !phase_q && sel_q != '0;
					if (phase_q || sel_q == '0) begin
						gap2_q <= sel_q != '0 && pv_free && ptr_q != '0;
						if (sel_q != '0 && pv_free) begin
							// drop the freed slot, and the next one too if it merged
							ptr_q <= sel_ext;
							cnt_q <= cnt_q - ((ptr_q != '0) ? CW'(2) : CW'(1));
						end else if (ptr_q != '0) begin
							cnt_q <= cnt_q - 1'b1;
						end else begin
							ptr_q <= cnt_q; // nothing to shift
						end
					end
				end
				S_SHDN: begin
					phase_q <= 1'b1;
					if (phase_q) ptr_q <= ptr_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					op_q <= mode;
					rsize_q <= req_size;
					rpid_q <= req_pid;
					rstat_q <= (mode == OP_APPEND && cnt_q >= FULL) ? ST_FULL : ST_OK;
					ridx_q <= '0;
					rbase_q <= '0;
					if (mode == OP_INIT && dyn_q) rlim_q <= msize_q - 1'b1;
					else if (mode == OP_APPEND && cnt_q == '0) rlim_q <= req_size - 1'b1;
					else rlim_q <= '0;
				end
			end
			S_SCAN: begin
				if (op_q == OP_APPEND) begin
					if (phase_q) begin
						ridx_q <= AW'(cnt_q);
						rbase_q <= rd_base + rd_size;
						rlim_q <= rd_base + rd_size + rsize_q - 1'b1;
					end
				end else if (phase_q && ptr_q < cnt_q) begin
					if ((op_q == OP_ALLOC && fit_ok && (!hit_q || better)) ||
					    (op_q != OP_ALLOC && own_ok && !hit_q)) begin
						sel_q <= ptr_q[AW-1:0];
						sbase_q <= rd_base;
						ssize_q <= rd_size;
					end
				end
			end
			S_DECIDE: begin
				if (op_q == OP_FREE) nsize_q <= ssize_q;
				if (!hit_q) begin
					rstat_q <= (op_q == OP_ALLOC) ? ST_NOFIT : ST_NOOWNER;
				end else if (op_q == OP_ALLOC && dyn_q && ssize_q != rsize_q &&
				             cnt_q >= FULL) begin
					rstat_q <= ST_FULL;
				end else begin
					ridx_q <= sel_q;
					rbase_q <= sbase_q;
					if (op_q == OP_ALLOC && dyn_q) rlim_q <= sbase_q + rsize_q - 1'b1;
					else rlim_q <= sbase_q + ssize_q - 1'b1;
				end
			end
			S_FREE_NX: begin
				if (phase_q && nx_free) nsize_q <= nsize_q + rd_size;
			end
			default: ;
		endcase
	end

endmodule
